// ===== hw/rtl/lkep_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkep_pkg
// Shared types and constants of the layered key event processor.
// ----------------------------------------------------------------------------
package lkep_pkg;

    localparam int LAYERS    = 3;
    localparam int KEY_W     = 5;
    localparam int LAYER_W   = 2;
    localparam int TYPE_W    = 4;
    localparam int VALUE_W   = 48;
    localparam int STAMP_W   = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int OP_W      = 2;
    localparam int MASK_W    = 2;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 64;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_W-1:0] OP_KEYMAP = 2'd1;
    localparam logic [OP_W-1:0] OP_MASK   = 2'd2;

    localparam logic [TYPE_W-1:0] TYPE_EMPTY = 4'd0;
    localparam logic [TYPE_W-1:0] TYPE_FN    = 4'd5;
    localparam logic [TYPE_W-1:0] TYPE_FN2   = 4'd6;

    localparam logic [LAYER_W-1:0] LAYER_BASE = 2'd0;
    localparam logic [LAYER_W-1:0] LAYER_FN   = 2'd1;
    localparam logic [LAYER_W-1:0] LAYER_FN2  = 2'd2;
    localparam logic [LAYER_W-1:0] LAYER_NONE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 2'd1;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd5;
    localparam logic [CFG_W-1:0] HOLD_RESET     = 16'd500;

    typedef struct packed {
        logic [TYPE_W-1:0]  etype;
        logic [VALUE_W-1:0] value;
    } t_entry;

    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic [LAYER_W-1:0]        active;
        logic [LAYERS-1:0]         rel;
        logic                      press;
        t_entry [LAYERS-1:0]       entry;
    } t_job;

endpackage

// ===== hw/rtl/lkep_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkep_front
// Accepts samples and table writes, reads the keymap, decides the events of
// each sample and updates per-slot state.
// ----------------------------------------------------------------------------
module lkep_front #(
    parameter int KEY_SLOTS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_valid,
    output logic                          o_s_ready,
    input  logic [lkep_pkg::S_TDATA_W-1:0] i_s_data,
    input  logic [lkep_pkg::OP_W-1:0]     i_s_op,
    input  logic [lkep_pkg::CFG_W-1:0]    i_debounce,
    input  logic [lkep_pkg::CFG_W-1:0]    i_hold,
    output logic                          o_job_valid,
    input  logic                          i_job_ready,
    output lkep_pkg::t_job                o_job
);
    import lkep_pkg::*;

    localparam int DEPTH = (KEY_SLOTS < 32) ? KEY_SLOTS : 32;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [KEY_W-1:0]   w_key;
    logic               w_level;
    logic [STAMP_W-1:0] w_now;
    logic [LAYER_W-1:0] w_layer;
    t_entry             w_entry;
    logic [MASK_W-1:0]  w_mask_in;
    logic               w_key_ok;
    logic [IDX_W-1:0]   w_idx;
    logic               w_accept;

    assign w_key          = i_s_data[4:0];
    assign w_level        = i_s_data[5];
    assign w_now          = i_s_data[37:6];
    assign w_layer        = i_s_data[39:38];
    assign w_entry.etype  = i_s_data[43:40];
    assign w_entry.value  = i_s_data[91:44];
    assign w_mask_in      = i_s_data[93:92];
    assign w_key_ok       = (32'(w_key) < 32'(KEY_SLOTS));
    assign w_idx          = w_key[IDX_W-1:0];
    assign w_accept       = i_s_valid && o_s_ready;

    t_entry             r_km [LAYERS][DEPTH];
    t_entry             r_rd [LAYERS];

    logic               r_s1_valid;
    logic               r_s1_mask_wr;
    logic [IDX_W-1:0]   r_s1_idx;
    logic [KEY_W-1:0]   r_s1_key;
    logic               r_s1_level;
    logic [STAMP_W-1:0] r_s1_now;
    logic [MASK_W-1:0]  r_s1_mask_in;

    logic [MASK_W-1:0]  r_mask    [DEPTH];
    logic               r_pressed [DEPTH];
    logic [STAMP_W-1:0] r_stamp   [DEPTH];
    logic [LAYERS-1:0]  r_held    [DEPTH];
    logic [LAYER_W-1:0] r_fn;

    logic [MASK_W-1:0]  w_mask;
    logic               w_pressed;
    logic [STAMP_W-1:0] w_stamp;
    logic [LAYERS-1:0]  w_held;
    logic [STAMP_W-1:0] w_elapsed;
    logic               w_deb_ok;
    logic               w_hold_ok;
    logic [LAYER_W-1:0] w_active;
    logic [LAYERS-1:0]  w_nonempty;
    logic [LAYERS-1:0]  w_other_rel;
    logic [LAYERS-1:0]  w_up_rel;
    logic [LAYERS-1:0]  w_rel;
    logic               w_press;
    logic               w_do_press;
    logic               w_do_hold;
    logic               w_do_rel;
    logic               w_is_sample;
    logic [LAYERS-1:0]  w_held_n;
    logic [LAYER_W-1:0] w_fn_n;
    logic               w_fn_rel;
    logic               w_has_ev;
    logic               w_advance;
    logic               w_edge;
    t_entry             w_act_entry;

    // keymap: one memory per layer, written and read at accept
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LAYERS; l++) begin
            if (w_accept && w_key_ok && (i_s_op == OP_KEYMAP) && (w_layer == LAYER_W'(l))) begin
                r_km[l][w_idx] <= w_entry;
            end
            if (w_accept) begin
                r_rd[l] <= r_km[l][w_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= w_key_ok && ((i_s_op == OP_SAMPLE) || (i_s_op == OP_MASK));
        end else if (w_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_mask_wr <= (i_s_op == OP_MASK);
            r_s1_idx     <= w_idx;
            r_s1_key     <= w_key;
            r_s1_level   <= w_level;
            r_s1_now     <= w_now;
            r_s1_mask_in <= w_mask_in;
        end
    end

    assign w_mask    = r_mask[r_s1_idx];
    assign w_pressed = r_pressed[r_s1_idx];
    assign w_stamp   = r_stamp[r_s1_idx];
    assign w_held    = r_held[r_s1_idx];
    assign w_elapsed = r_s1_now - w_stamp;
    assign w_deb_ok  = (w_elapsed >= {16'd0, i_debounce});
    assign w_hold_ok = (w_elapsed >= {16'd0, i_hold});

    always_comb begin
        w_active = r_fn & w_mask;
        if (w_active == LAYER_NONE) begin
            w_active = LAYER_BASE;
        end
        for (int n = 0; n < LAYERS; n++) begin
            w_nonempty[n]  = (r_rd[n].etype != TYPE_EMPTY);
            w_other_rel[n] = (LAYER_W'(n) != w_active) && w_nonempty[n] && w_held[n];
            w_up_rel[n]    = w_held[n] && w_nonempty[n] && ((n == 0) || (w_mask != '0));
        end
        w_act_entry = r_rd[w_active];
        w_is_sample = !r_s1_mask_wr;
        w_do_press  = w_is_sample && r_s1_level && !w_pressed && w_deb_ok;
        w_do_hold   = w_is_sample && r_s1_level && w_pressed && w_hold_ok;
        w_do_rel    = w_is_sample && !r_s1_level && w_pressed;
        w_edge      = w_is_sample && (r_s1_level != w_pressed);

        if (w_do_press || w_do_hold) begin
            w_rel = w_other_rel;
        end else if (w_do_rel) begin
            w_rel = w_up_rel;
        end else begin
            w_rel = '0;
        end
        w_press  = w_do_press && w_nonempty[w_active];
        w_held_n = (w_held & ~w_rel) | (w_do_press ? (3'b001 << w_active) : 3'b000);

        w_fn_rel = 1'b0;
        for (int n = 0; n < LAYERS; n++) begin
            if (w_rel[n] && ((r_rd[n].etype == TYPE_FN) || (r_rd[n].etype == TYPE_FN2))) begin
                w_fn_rel = 1'b1;
            end
        end
        if (w_press && (w_act_entry.etype == TYPE_FN)) begin
            w_fn_n = LAYER_FN;
        end else if (w_press && (w_act_entry.etype == TYPE_FN2)) begin
            w_fn_n = LAYER_FN2;
        end else if (w_fn_rel) begin
            w_fn_n = LAYER_BASE;
        end else begin
            w_fn_n = r_fn;
        end

        w_has_ev  = (|w_rel) || w_press;
        w_advance = r_s1_valid && (!w_has_ev || i_job_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fn <= LAYER_BASE;
            for (int s = 0; s < DEPTH; s++) begin
                r_mask[s]    <= '0;
                r_pressed[s] <= 1'b0;
                r_stamp[s]   <= '0;
                r_held[s]    <= '0;
            end
        end else if (w_advance) begin
            if (r_s1_mask_wr) begin
                r_mask[r_s1_idx] <= r_s1_mask_in;
            end else begin
                r_fn             <= w_fn_n;
                r_held[r_s1_idx] <= w_held_n;
                if (w_edge) begin
                    r_pressed[r_s1_idx] <= r_s1_level;
                    r_stamp[r_s1_idx]   <= r_s1_now;
                end
            end
        end
    end

    assign o_s_ready   = !r_s1_valid || w_advance;
    assign o_job_valid = r_s1_valid && w_has_ev;

    always_comb begin
        o_job.key    = r_s1_key;
        o_job.active = w_active;
        o_job.rel    = w_rel;
        o_job.press  = w_press;
        for (int n = 0; n < LAYERS; n++) begin
            o_job.entry[n] = r_rd[n];
        end
    end

endmodule

// ===== hw/rtl/lkep_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkep_queue
// Short job queue between the classifying front and the event sequencer.
// ----------------------------------------------------------------------------
module lkep_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  lkep_pkg::t_job i_push_job,
    output logic           o_pop_valid,
    input  logic           i_pop,
    output lkep_pkg::t_job o_pop_job
);
    import lkep_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_push;
    logic              w_pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/lkep_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkep_back
// Walks the pending events of each job in layer order, press last, and
// drives the registered result stage.
// ----------------------------------------------------------------------------
module lkep_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    input  lkep_pkg::t_job                i_job,
    output logic                          o_job_pop,
    output logic                          o_m_valid,
    input  logic                          i_m_ready,
    output logic [lkep_pkg::KEY_W-1:0]    o_m_key,
    output logic [lkep_pkg::LAYER_W-1:0]  o_m_layer,
    output logic [lkep_pkg::TYPE_W-1:0]   o_m_type,
    output logic [lkep_pkg::VALUE_W-1:0]  o_m_value,
    output logic                          o_m_release,
    output logic                          o_m_last
);
    import lkep_pkg::*;

    t_job               r_cur;
    logic [3:0]         r_pend;
    logic               r_out_valid;
    logic               w_have;
    logic               w_space;
    logic               w_emit;
    logic               w_load;
    logic [3:0]         w_sel_bit;
    logic [3:0]         w_left;
    logic [LAYER_W-1:0] w_sel_layer;
    logic               w_sel_rel;
    t_entry             w_sel_entry;

    always_comb begin
        if (r_pend[0]) begin
            w_sel_bit   = 4'b0001;
            w_sel_layer = LAYER_BASE;
            w_sel_rel   = 1'b1;
        end else if (r_pend[1]) begin
            w_sel_bit   = 4'b0010;
            w_sel_layer = LAYER_FN;
            w_sel_rel   = 1'b1;
        end else if (r_pend[2]) begin
            w_sel_bit   = 4'b0100;
            w_sel_layer = LAYER_FN2;
            w_sel_rel   = 1'b1;
        end else begin
            w_sel_bit   = 4'b1000;
            w_sel_layer = r_cur.active;
            w_sel_rel   = 1'b0;
        end
        w_sel_entry = r_cur.entry[w_sel_layer];
        w_left      = r_pend & ~w_sel_bit;
        w_have      = (r_pend != '0);
        w_space     = !r_out_valid || i_m_ready;
        w_emit      = w_have && w_space;
        w_load      = i_job_valid && (!w_have || (w_emit && (w_left == '0)));
    end

    assign o_job_pop = w_load;
    assign o_m_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_pend <= {i_job.press, i_job.rel};
            end else if (w_emit) begin
                r_pend <= w_left;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cur <= i_job;
        end
        if (w_emit) begin
            o_m_key     <= r_cur.key;
            o_m_layer   <= w_sel_layer;
            o_m_type    <= w_sel_entry.etype;
            o_m_value   <= w_sel_entry.value;
            o_m_release <= w_sel_rel;
            o_m_last    <= (w_left == '0);
        end
    end

endmodule

// ===== hw/rtl/layered_key_event_processor_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layered_key_event_processor_core
// Layered keymap press/release event generator with debounce and hold.
//
// Input stream: one transfer per key sample (tuser op 0), keymap write (op 1)
// or layer mask write (op 2). A sample yields zero to three events on the
// output stream; tlast marks the last event of a sample, tuser marks release.
// Config channel: index 0 debounce time, index 1 hold time, in ms; write
// only while the block is idle. o_cfg_ready is always high.
// Path: the first event of a sample passes the front stage register, the job
// queue and the back-end job register before it leaves the output register.
// Throughput: one input transfer per cycle unless a full queue holds the front
// stage; the back-end sequencer emits a sample's events one by one and a
// sample without events never reaches it; the two-entry queue absorbs bursts.
// Per-slot state is read and written in the same front stage, so back-to-back
// samples of one slot see each other's updates.
// Reset clears slot state, fn layer and the pipeline; keymap contents are
// undefined until written. A stalled output holds its event and, once the
// queue fills, input tready drops.
// ----------------------------------------------------------------------------
module layered_key_event_processor_core #(
    parameter int KEY_SLOTS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // key[4:0], level[5], now_ms[37:6], layer[39:38], entry_type[43:40],
    // entry_value[91:44], mask_in[93:92], zero fill
    input  logic [lkep_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    // op[1:0]
    input  logic [lkep_pkg::OP_W-1:0]         i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // out_key[4:0], out_layer[6:5], out_type[10:7], out_value[58:11], zero fill
    output logic [lkep_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    // out_release[0]
    output logic                              o_m_axis_tuser,
    output logic                              o_m_axis_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lkep_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lkep_pkg::CFG_W-1:0]        i_cfg_data
);
    import lkep_pkg::*;

    logic [CFG_W-1:0]   r_debounce;
    logic [CFG_W-1:0]   r_hold;
    logic               w_job_valid;
    logic               w_job_ready;
    t_job               w_job;
    logic               w_q_valid;
    logic               w_q_pop;
    t_job               w_q_job;
    logic [KEY_W-1:0]   w_key;
    logic [LAYER_W-1:0] w_layer;
    logic [TYPE_W-1:0]  w_type;
    logic [VALUE_W-1:0] w_value;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
            r_hold     <= HOLD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DEBOUNCE: r_debounce <= i_cfg_data;
                CFG_HOLD:     r_hold     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    lkep_front #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (i_s_axis_tvalid),
        .o_s_ready   (o_s_axis_tready),
        .i_s_data    (i_s_axis_tdata),
        .i_s_op      (i_s_axis_tuser),
        .i_debounce  (r_debounce),
        .i_hold      (r_hold),
        .o_job_valid (w_job_valid),
        .i_job_ready (w_job_ready),
        .o_job       (w_job)
    );

    lkep_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_job_valid),
        .o_push_ready (w_job_ready),
        .i_push_job   (w_job),
        .o_pop_valid  (w_q_valid),
        .i_pop        (w_q_pop),
        .o_pop_job    (w_q_job)
    );

    lkep_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_q_valid),
        .i_job       (w_q_job),
        .o_job_pop   (w_q_pop),
        .o_m_valid   (o_m_axis_tvalid),
        .i_m_ready   (i_m_axis_tready),
        .o_m_key     (w_key),
        .o_m_layer   (w_layer),
        .o_m_type    (w_type),
        .o_m_value   (w_value),
        .o_m_release (o_m_axis_tuser),
        .o_m_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {5'd0, w_value, w_type, w_layer, w_key};

endmodule
